FILE: hdl/kts_pkg.sv
`timescale 1ns / 1ps

package kts_pkg;

  localparam int FIELD_W   = 32;
  localparam int NOISE_W   = 25;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int VAR_W     = 32;
  localparam int DEN_W     = 33;
  localparam int GAIN_W    = 25;
  localparam int DIV_STEPS = 25;
  localparam int MA_W      = 26;
  localparam int MB_W      = 34;
  localparam int MP_W      = MA_W + MB_W;
  localparam int SUM_W     = 37;
  localparam int OSUM_W    = 34;
  localparam int FRAC_W    = 24;

  localparam logic [NOISE_W-1:0] PROC_NOISE_RST = 25'd67109;
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = 25'd4194304;
  localparam logic [VAR_W-1:0]   VAR_ONE        = 32'h0100_0000;
  localparam logic [GAIN_W-1:0]  GAIN_ONE       = 25'h100_0000;

  localparam logic REG_PROC_NOISE = 1'b0;
  localparam logic REG_MEAS_NOISE = 1'b1;

  typedef logic signed [FIELD_W-1:0] field_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic field_t sat32(input logic signed [OSUM_W-1:0] v);
    logic signed [OSUM_W-1:0] hi;
    logic signed [OSUM_W-1:0] lo;
    hi = OSUM_W'(signed'({1'b0, {(FIELD_W-1){1'b1}}}));
    lo = OSUM_W'(signed'({1'b1, {(FIELD_W-1){1'b0}}}));
    if (v > hi) begin
      return hi[FIELD_W-1:0];
    end else if (v < lo) begin
      return lo[FIELD_W-1:0];
    end
    return v[FIELD_W-1:0];
  endfunction

endpackage

FILE: hdl/kts_if.sv
`timescale 1ns / 1ps

interface kts_in_if;
  import kts_pkg::*;

  logic   valid;
  logic   ready;
  field_t shift_x;
  field_t shift_y;
  field_t turn_angle;

  modport source(output valid, output shift_x, output shift_y, output turn_angle,
                 input ready);
  modport sink(input valid, input shift_x, input shift_y, input turn_angle,
               output ready);
endinterface

interface kts_out_if;
  import kts_pkg::*;

  logic   valid;
  logic   ready;
  field_t fixed_x;
  field_t fixed_y;
  field_t fixed_angle;

  modport source(output valid, output fixed_x, output fixed_y, output fixed_angle,
                 input ready);
  modport sink(input valid, input fixed_x, input fixed_y, input fixed_angle,
               output ready);
endinterface

FILE: hdl/kts_div.sv
`timescale 1ns / 1ps

module kts_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [kts_pkg::VAR_W-1:0]     pp_i,
  input  logic [kts_pkg::DEN_W-1:0]     den_i,
  output kts_pkg::div_stat_t            stat_o,
  output logic [kts_pkg::GAIN_W-1:0]    quot_o
);
  import kts_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W = DEN_W + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic [REM_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [GAIN_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              zero_q, zero_d;
  logic [REM_W:0]    trial;
  logic              qbit;
  logic [REM_W-1:0]  rem_keep;

  // restoring division, one quotient bit per cycle
  assign trial    = {1'b0, rem_q} - {2'b00, den_q};
  assign qbit     = ~trial[REM_W];
  assign rem_keep = qbit ? trial[REM_W-1:0] : rem_q;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    zero_d = zero_q;
    if (start_i) begin
      rem_d  = REM_W'(pp_i);
      den_d  = den_i;
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      zero_d = (den_i == '0);
    end else if (busy_q) begin
      rem_d  = {rem_keep[REM_W-2:0], 1'b0};
      quot_d = {quot_q[GAIN_W-2:0], qbit};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    zero_q <= zero_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == CNT_LAST);
  assign quot_o      = zero_q ? '0 : quot_q;

endmodule

FILE: hdl/kts_mul.sv
`timescale 1ns / 1ps

module kts_mul (
  input  logic                              clk_i,
  input  logic signed [kts_pkg::MA_W-1:0]   a_i,
  input  logic signed [kts_pkg::MB_W-1:0]   b_i,
  output logic signed [kts_pkg::MP_W-1:0]   p_o
);
  import kts_pkg::*;

  logic signed [MP_W-1:0] p_q, p_d;

  assign p_d = MP_W'(a_i) * MP_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

FILE: hdl/kalman_trajectory_smoother_unit.sv
// first frame: the request goes from idle straight to the output state; later frames pass the
//   25-step gain divider, then four passes through the shared multiplier, then the output state
// a new request is taken only in idle, once the last one has reached the output register
// a finished result waits in the output register while the next request is taken
// reset: asynchronous active low; trajectory and estimate clear, variance to 1.0
`timescale 1ns / 1ps

module kalman_trajectory_smoother_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  kts_in_if.sink                        in_chan,
  kts_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kts_pkg::PADDR_W-1:0]   paddr,
  input  logic [kts_pkg::PDATA_W-1:0]   pwdata,
  output logic [kts_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import kts_pkg::*;

  localparam int AW = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
  localparam int RW = AW + 1;
  localparam longint ACC_MAX = (64'sd1 <<< (AW - 1)) - 64'sd1;
  localparam longint ACC_MIN = -ACC_MAX - 64'sd1;

  typedef logic signed [AW-1:0] acc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_WB,
    S_OUT
  } state_e;

  localparam logic [1:0] IDX_VAR = 2'd3;

  function automatic acc_t sat_acc(input logic signed [SUM_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > ACC_MAX) begin
      return AW'(ACC_MAX);
    end else if (w < ACC_MIN) begin
      return AW'(ACC_MIN);
    end
    return v[AW-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [1:0]           idx_q, idx_d;
  acc_t                 path_q[3], path_d[3];
  acc_t                 est_q[3], est_d[3];
  logic [VAR_W-1:0]     var_q, var_d;
  logic                 first_q, first_d;
  logic [VAR_W-1:0]     pp_q, pp_d;
  field_t               motion_q[3], motion_d[3];
  logic                 out_valid_q, out_valid_d;
  field_t               fixed_q[3], fixed_d[3];
  logic [NOISE_W-1:0]   proc_noise_q;
  logic [NOISE_W-1:0]   meas_noise_q;

  field_t               motion_in[3];
  acc_t                 path_next[3];
  field_t               fixed_now[3];
  logic                 in_fire;
  logic [VAR_W:0]       pp_sum;
  logic [VAR_W-1:0]     pp_now;
  logic [DEN_W-1:0]     den_now;
  div_stat_t            div_stat;
  logic [GAIN_W-1:0]    gain;
  logic signed [RW-1:0] res_sel;
  acc_t                 est_sel;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod;
  logic signed [SUM_W-1:0] est_sum;
  acc_t                 est_upd;
  logic [VAR_W-1:0]     var_upd;
  logic                 cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MEAS_NOISE) ? PDATA_W'(meas_noise_q)
                                               : PDATA_W'(proc_noise_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_noise_q <= PROC_NOISE_RST;
      meas_noise_q <= MEAS_NOISE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MEAS_NOISE) begin
        meas_noise_q <= pwdata[NOISE_W-1:0];
      end else begin
        proc_noise_q <= pwdata[NOISE_W-1:0];
      end
    end
  end

  // request side
  assign motion_in[0] = in_chan.shift_x;
  assign motion_in[1] = in_chan.shift_y;
  assign motion_in[2] = in_chan.turn_angle;
  assign in_chan.ready = (state_q == S_IDLE);
  assign in_fire = in_chan.valid && in_chan.ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      path_next[i] = sat_acc(SUM_W'(path_q[i]) + SUM_W'(motion_in[i]));
      fixed_now[i] = sat32(OSUM_W'(motion_q[i]) + OSUM_W'(est_q[i]) - OSUM_W'(path_q[i]));
    end
  end

  // predicted variance and gain denominator
  assign pp_sum  = {1'b0, var_q} + (VAR_W + 1)'(proc_noise_q);
  assign pp_now  = pp_sum[VAR_W] ? '1 : pp_sum[VAR_W-1:0];
  assign den_now = {1'b0, pp_now} + DEN_W'(meas_noise_q);

  kts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire && first_q == 1'b0),
    .pp_i    (pp_now),
    .den_i   (den_now),
    .stat_o  (div_stat),
    .quot_o  (gain)
  );

  // shared multiplier operand select
  always_comb begin
    case (idx_q)
      2'd0:    est_sel = est_q[0];
      2'd1:    est_sel = est_q[1];
      2'd2:    est_sel = est_q[2];
      default: est_sel = '0;
    endcase
    case (idx_q)
      2'd0:    res_sel = RW'(path_q[0]) - RW'(est_q[0]);
      2'd1:    res_sel = RW'(path_q[1]) - RW'(est_q[1]);
      2'd2:    res_sel = RW'(path_q[2]) - RW'(est_q[2]);
      default: res_sel = '0;
    endcase
    if (idx_q == IDX_VAR) begin
      mul_a = signed'({1'b0, GAIN_ONE - gain});
      mul_b = signed'(MB_W'(pp_q));
    end else begin
      mul_a = signed'({1'b0, gain});
      mul_b = MB_W'(res_sel);
    end
  end

  kts_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // round half up: floor(p / 2^24) plus bit 23
  assign est_sum = SUM_W'(est_sel) + SUM_W'(signed'(prod[MP_W-1:FRAC_W]))
                 + SUM_W'(prod[FRAC_W-1]);
  assign est_upd = sat_acc(est_sum);
  assign var_upd = prod[FRAC_W+VAR_W-1:FRAC_W] + VAR_W'(prod[FRAC_W-1]);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    path_d      = path_q;
    est_d       = est_q;
    var_d       = var_q;
    first_d     = first_q;
    pp_d        = pp_q;
    motion_d    = motion_q;
    out_valid_d = out_valid_q;
    fixed_d     = fixed_q;
    if (out_chan.valid && out_chan.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          motion_d = motion_in;
          path_d   = path_next;
          pp_d     = pp_now;
          if (first_q) begin
            est_d   = '{default: '0};
            var_d   = VAR_ONE;
            first_d = 1'b0;
            state_d = S_OUT;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          idx_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_WB;
      end
      S_WB: begin
        if (idx_q == IDX_VAR) begin
          var_d   = var_upd;
          state_d = S_OUT;
        end else begin
          est_d[idx_q] = est_upd;
          idx_d        = idx_q + 2'd1;
          state_d      = S_MUL;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_chan.ready) begin
          fixed_d     = fixed_now;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      path_q      <= '{default: '0};
      est_q       <= '{default: '0};
      var_q       <= VAR_ONE;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      path_q      <= path_d;
      est_q       <= est_d;
      var_q       <= var_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q     <= pp_d;
    motion_q <= motion_d;
    fixed_q  <= fixed_d;
  end

  // result side
  assign out_chan.valid       = out_valid_q;
  assign out_chan.fixed_x     = fixed_q[0];
  assign out_chan.fixed_y     = fixed_q[1];
  assign out_chan.fixed_angle = fixed_q[2];

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_div_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == S_DIV)
    else $error("divider running outside the divide state");

  a_gain_at_most_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_stat.done) |=> gain <= GAIN_ONE)
    else $error("gain above 1.0");

  a_first_clears_on_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(first_q) |-> $past(in_fire))
    else $error("first frame flag cleared without a request");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && state_d == S_IDLE) |=> out_valid_q)
    else $error("result not presented after finishing");
`endif

endmodule

FILE: bench/kalman_trajectory_smoother_unit_tb.sv
`timescale 1ns / 1ps

module kalman_trajectory_smoother_unit_tb;
  import kts_pkg::*;

  localparam int DATA_W      = 32;
  localparam int ACC_W       = (DATA_W > 32) ? 32 : ((DATA_W < 16) ? 16 : DATA_W);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int DRAIN_WAIT  = 40;

  localparam logic [PADDR_W-1:0] PROC_NOISE_ADDR = {REG_PROC_NOISE, 2'b00};
  localparam logic [PADDR_W-1:0] MEAS_NOISE_ADDR = {REG_MEAS_NOISE, 2'b00};

  localparam field_t F_MAX = 32'h7FFF_FFFF;
  localparam field_t F_MIN = 32'h8000_0000;
  localparam field_t F_ONE = 32'h0001_0000;

  localparam logic [PDATA_W-1:0] NOISE_TOP = 32'd16777216;

  localparam longint ONE_Q24  = 64'sd1 <<< FRAC_W;
  localparam longint HALF_Q24 = 64'sd1 <<< (FRAC_W - 1);
  localparam longint U32_MAX  = 64'sh0000_0000_FFFF_FFFF;
  localparam longint ACC_HI   = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO   = -ACC_HI - 1;
  localparam longint OUT_HI   = 64'sd2147483647;
  localparam longint OUT_LO   = -64'sd2147483648;

  typedef struct packed {
    field_t x;
    field_t y;
    field_t a;
  } motion_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  kts_in_if  in_chan ();
  kts_out_if out_chan ();

  kalman_trajectory_smoother_unit #(
    .DATA_WIDTH(DATA_W)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // filter state mirror
  longint             traj [3];
  longint             est [3];
  logic [VAR_W-1:0]   err_var;
  bit                 first_pending;
  logic [NOISE_W-1:0] q_noise;
  logic [NOISE_W-1:0] r_noise;

  motion_t pending_fixes [$];
  int      errors = 0;
  int      cycle_count = 0;
  int      tx_burst = 0;

  int   rx_mode = 0;
  int   rx_span = 0;
  int   rx_hold = 0;
  logic rx_level = 1'b0;

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic motion_t smooth_motion(motion_t m);
    longint  mv [3];
    longint  pp;
    longint  den;
    longint  gain;
    longint  stp;
    longint  v [3];
    motion_t r;
    mv[0] = longint'(signed'(m.x));
    mv[1] = longint'(signed'(m.y));
    mv[2] = longint'(signed'(m.a));
    for (int i = 0; i < 3; i++) begin
      traj[i] = clamp64(traj[i] + mv[i], ACC_LO, ACC_HI);
    end
    if (first_pending) begin
      for (int i = 0; i < 3; i++) begin
        est[i] = 0;
      end
      err_var = VAR_ONE;
      first_pending = 1'b0;
    end else begin
      pp = longint'(err_var) + longint'(q_noise);
      if (pp > U32_MAX) begin
        pp = U32_MAX;
      end
      den = pp + longint'(r_noise);
      gain = (den != 0) ? ((pp <<< FRAC_W) / den) : 0;
      for (int i = 0; i < 3; i++) begin
        stp = (gain * (traj[i] - est[i]) + HALF_Q24) >>> FRAC_W;
        est[i] = clamp64(est[i] + stp, ACC_LO, ACC_HI);
      end
      err_var = VAR_W'(((ONE_Q24 - gain) * pp + HALF_Q24) >>> FRAC_W);
    end
    for (int i = 0; i < 3; i++) begin
      v[i] = clamp64(mv[i] + est[i] - traj[i], OUT_LO, OUT_HI);
    end
    r.x = field_t'(v[0]);
    r.y = field_t'(v[1]);
    r.a = field_t'(v[2]);
    return r;
  endfunction

  function automatic void check_field(string name, field_t want, field_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // result checker
  motion_t want_fix;
  always @(posedge clk_i) begin
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      if (pending_fixes.size() == 0) begin
        $error("result with no request pending: %0d %0d %0d",
               out_chan.fixed_x, out_chan.fixed_y, out_chan.fixed_angle);
        errors++;
      end else begin
        want_fix = pending_fixes.pop_front();
        check_field("fixed_x", want_fix.x, out_chan.fixed_x);
        check_field("fixed_y", want_fix.y, out_chan.fixed_y);
        check_field("fixed_angle", want_fix.a, out_chan.fixed_angle);
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_span = $urandom_range(64, 512);
    end
    rx_span--;
    case (rx_mode)
      0: begin
        out_chan.ready <= 1'b1;
      end
      1: begin
        out_chan.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (rx_hold == 0) begin
          rx_level = ~rx_level;
          rx_hold = rx_level ? $urandom_range(1, 4) : $urandom_range(1, 40);
        end
        rx_hold--;
        out_chan.ready <= rx_level;
      end
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_noise(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == PROC_NOISE_ADDR) begin
      q_noise = data[NOISE_W-1:0];
    end else begin
      r_noise = data[NOISE_W-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_noise(logic [PDATA_W-1:0] q, logic [PDATA_W-1:0] r);
    write_noise(PROC_NOISE_ADDR, q);
    write_noise(MEAS_NOISE_ADDR, r);
  endtask

  task automatic send_motion(field_t x, field_t y, field_t a);
    motion_t m;
    int      gap;
    m.x = x;
    m.y = y;
    m.a = a;
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0
            : $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    tx_burst--;
    in_chan.valid      <= 1'b1;
    in_chan.shift_x    <= x;
    in_chan.shift_y    <= y;
    in_chan.turn_angle <= a;
    do @(posedge clk_i); while (!in_chan.ready);
    pending_fixes.insert(pending_fixes.size(), smooth_motion(m));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_fixes.size() != 0) @(negedge clk_i);
  endtask

  function automatic field_t rand_motion();
    case ($urandom_range(0, 9))
      0: return field_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return F_MAX;
          1: return F_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      // typical frame jitter, within about 16 pixels
      default: return field_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic logic [PDATA_W-1:0] rand_noise(logic [PDATA_W-1:0] floor_val);
    case ($urandom_range(0, 4))
      0: return floor_val;
      1: return NOISE_TOP;
      2: return $urandom;
      default: return $urandom_range(floor_val, NOISE_TOP);
    endcase
  endfunction

  task automatic test_first_frame_and_extremes();
    send_motion(32'h0001_8000, 32'hFFFD_C000, 32'h0000_028F);
    send_motion('0, '0, '0);
    send_motion(F_MAX, F_MAX, F_MAX);
    send_motion(F_MAX, F_MIN, F_MAX);
    send_motion(F_MAX, F_MIN, '0);
    send_motion(F_MIN, F_MAX, F_MIN);
    send_motion(F_MIN, F_MAX, F_MIN);
    send_motion(F_MIN, F_MIN, F_MIN);
    send_motion('1, F_ONE, -F_ONE);
    send_motion(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001);
    drain();
  endtask

  task automatic test_register_extremes();
    set_noise(NOISE_TOP, 32'd1);
    repeat (3) send_motion(F_ONE, -F_ONE, 32'h0000_1000);
    drain();
    set_noise('0, NOISE_TOP);
    repeat (3) send_motion(32'h0003_0000, 32'h7FF0_0000, 32'hFFFF_F000);
    drain();
    // upper bits are dropped by the 25-bit registers
    set_noise(32'hFFFF_FFFF, 32'hFE00_0000);
    repeat (3) send_motion(F_MIN, 32'h0000_8000, F_MAX);
    drain();
  endtask

  task automatic test_zero_denominator();
    // unity gain drives variance to zero, then the denominator is zero
    set_noise('0, '0);
    send_motion(32'h0002_0000, 32'hFFFF_0000, 32'h0000_0100);
    send_motion(32'h0010_0000, 32'h0000_4000, 32'hFFFF_FF00);
    send_motion(F_MAX, F_MIN, 32'h0000_0001);
    drain();
  endtask

  task automatic test_random_motion();
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        set_noise(32'(PROC_NOISE_RST), 32'(MEAS_NOISE_RST));
      end else begin
        set_noise(rand_noise('0), rand_noise(32'd1));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_motion(rand_motion(), rand_motion(), rand_motion());
      end
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      traj[i] = 0;
      est[i]  = 0;
    end
    err_var       = VAR_ONE;
    first_pending = 1'b1;
    q_noise       = PROC_NOISE_RST;
    r_noise       = MEAS_NOISE_RST;

    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_chan.valid       = 1'b0;
    in_chan.shift_x     = '0;
    in_chan.shift_y     = '0;
    in_chan.turn_angle  = '0;
    out_chan.ready      = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_first_frame_and_extremes();
    test_register_extremes();
    test_zero_denominator();
    test_random_motion();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0 && pending_fixes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/kts_pkg.sv
hdl/kts_if.sv
hdl/kts_div.sv
hdl/kts_mul.sv
hdl/kalman_trajectory_smoother_unit.sv
bench/kalman_trajectory_smoother_unit_tb.sv
